/* rtl/fglb_pkg.sv */
// Package for the Fibonacci-growth list buffer.
// Holds the sizes, operation and status codes, the cell command struct and the capacity table.
// No dependencies.
`default_nettype none

package fglb_pkg;

    // Sizes of the list store and its fields.
    localparam int DEPTH       = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int FILL_W      = $clog2(DEPTH + 1);
    localparam int CAP_W       = 7;
    localparam int CMP_W       = (FILL_W > CAP_W) ? FILL_W : CAP_W;
    localparam int LEVEL_W     = 4;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;

    // Level limits.
    localparam logic [LEVEL_W-1:0] LEVEL_RESET      = LEVEL_W'(2);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX        = LEVEL_W'(15);
    localparam logic [LEVEL_W-1:0] LEVEL_SHRINK_MIN = LEVEL_W'(3);
    localparam logic [CAP_W-1:0]   CAP_RESET        = CAP_W'(1);

    // Operation codes of a request.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH   = 3'd0,
        FUNC_POP    = 3'd1,
        FUNC_INSERT = 3'd2,
        FUNC_REMOVE = 3'd3,
        FUNC_LOOKUP = 3'd4
    } func_t;

    // Status codes of a response.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_RANGE     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Command broadcast from the control unit to every cell.
    typedef struct packed {
        logic                         push_en;
        logic                         ins_en;
        logic                         rem_en;
        logic [IDX_W-1:0]             index;
        logic [FILL_W-1:0]            fill;
        logic signed [DATA_WIDTH-1:0] value;
    } bcast_t;

    // Fibonacci number of a level; levels past the physical depth never occur.
    function automatic logic [CAP_W-1:0] fib_of(input logic [LEVEL_W-1:0] level);
        logic [CAP_W-1:0] fib;
        case (level)
            4'd0:    fib = CAP_W'(0);
            4'd1:    fib = CAP_W'(1);
            4'd2:    fib = CAP_W'(1);
            4'd3:    fib = CAP_W'(2);
            4'd4:    fib = CAP_W'(3);
            4'd5:    fib = CAP_W'(5);
            4'd6:    fib = CAP_W'(8);
            4'd7:    fib = CAP_W'(13);
            4'd8:    fib = CAP_W'(21);
            4'd9:    fib = CAP_W'(34);
            4'd10:   fib = CAP_W'(55);
            4'd11:   fib = CAP_W'(89);
            4'd12:   fib = CAP_W'(144);
            4'd13:   fib = CAP_W'(233);
            4'd14:   fib = CAP_W'(377);
            4'd15:   fib = CAP_W'(610);
            default: fib = CAP_W'(0);
        endcase
        return fib;
    endfunction

endpackage

`default_nettype wire

/* rtl/fglb_if.sv */
// Request and response channel interfaces of the Fibonacci-growth list buffer.
// Depends on fglb_pkg.
`default_nettype none

// Request channel: one list operation.
interface fglb_req_if import fglb_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [FUNC_W-1:0]            func;
    logic signed [DATA_WIDTH-1:0] value;
    logic [IDX_W-1:0]             index;

    modport source (output valid, output func, output value, output index, input ready);
    modport sink   (input valid, input func, input value, input index, output ready);
endinterface

// Response channel: status, word and list size after the operation.
interface fglb_rsp_if import fglb_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [STATUS_W-1:0]          status;
    logic signed [DATA_WIDTH-1:0] data_out;
    logic [FILL_W-1:0]            fill;
    logic [CAP_W-1:0]             capacity_now;

    modport source (output valid, output status, output data_out, output fill,
                    output capacity_now, input ready);
    modport sink   (input valid, input status, input data_out, input fill,
                    input capacity_now, output ready);
endinterface

`default_nettype wire

/* rtl/fglb_cell.sv */
// One storage cell of the list chain: holds one word and decides locally to hold,
// load the new word, or take its left or right neighbor. Depends on fglb_pkg.
`default_nettype none

module fglb_cell
    import fglb_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic [IDX_W-1:0]             pos,
    input  wire bcast_t                       bcast,
    input  wire logic signed [DATA_WIDTH-1:0] left_word,
    input  wire logic signed [DATA_WIDTH-1:0] right_word,
    input  wire logic [IDX_W-1:0]             rd_idx,
    output logic signed [DATA_WIDTH-1:0]      word,
    output logic signed [DATA_WIDTH-1:0]      rd_word
);

    logic signed [DATA_WIDTH-1:0] word_reg;
    logic signed [DATA_WIDTH-1:0] word_next;
    logic [FILL_W-1:0]            pos_ext;
    logic [FILL_W-1:0]            pos_plus1;

    assign pos_ext   = FILL_W'(pos);
    assign pos_plus1 = pos_ext + FILL_W'(1);

    // Local decision from the broadcast command and this cell's position.
    always_comb
    begin
        word_next = word_reg;
        if (bcast.push_en && (pos_ext == bcast.fill))
        begin
            word_next = bcast.value;
        end
        else if (bcast.ins_en)
        begin
            if (pos == bcast.index)
            begin
                word_next = bcast.value;
            end
            else if ((pos > bcast.index) && (pos_ext <= bcast.fill))
            begin
                word_next = left_word;
            end
        end
        else if (bcast.rem_en && (pos >= bcast.index) && (pos_plus1 < bcast.fill))
        begin
            word_next = right_word;
        end
    end

    // Word storage.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = (pos == rd_idx) ? word_reg : '0;

endmodule

`default_nettype wire

/* rtl/fglb_ctrl.sv */
// Control unit of the list buffer: handshake, fill count, Fibonacci level and capacity,
// the command broadcast to the cells, and the response register. Depends on fglb_pkg, fglb_if.
`default_nettype none

module fglb_ctrl
    import fglb_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    fglb_req_if.sink                          req,
    fglb_rsp_if.source                        rsp,
    input  wire logic signed [DATA_WIDTH-1:0] rd_data,
    output bcast_t                            bcast,
    output logic [IDX_W-1:0]                  rd_idx
);

    logic [FILL_W-1:0]            fill_reg, fill_next;
    logic [LEVEL_W-1:0]           level_reg, level_next;
    logic [CAP_W-1:0]             cap_reg, cap_next;
    logic                         rsp_valid_reg;
    logic [STATUS_W-1:0]          status_reg;
    status_t                      status_next;
    logic signed [DATA_WIDTH-1:0] data_reg, data_next;

    logic              accept;
    logic [FILL_W-1:0] idx_ext;
    logic [FILL_W-1:0] fill_dec;
    logic              is_full;
    logic              is_empty;
    logic              at_cap;
    logic              do_push, do_ins, do_rem, do_read, do_grow, do_shrink;
    logic              ins_legal;
    logic [CAP_W-1:0]  shrink_bound;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign idx_ext      = FILL_W'(req.index);
    assign fill_dec     = fill_reg - FILL_W'(1);
    assign is_full      = (fill_reg == FILL_W'(DEPTH));
    assign is_empty     = (fill_reg == '0);
    assign at_cap       = (CMP_W'(fill_reg) == CMP_W'(cap_reg));
    assign ins_legal    = (idx_ext < fill_reg) || (is_empty && (req.index == '0));
    assign shrink_bound = fib_of(level_reg - LEVEL_W'(2));

    // Decode the operation into status and actions.
    always_comb
    begin
        status_next = ST_OK;
        do_push     = 1'b0;
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        do_read     = 1'b0;
        rd_idx      = req.index;
        case (func_t'(req.func))
            FUNC_PUSH:
            begin
                if (is_full)
                    status_next = ST_FULL;
                else
                    do_push = 1'b1;
            end
            FUNC_POP:
            begin
                rd_idx = fill_dec[IDX_W-1:0];
                if (is_empty)
                    status_next = ST_UNDERFLOW;
                else
                    do_read = 1'b1;
            end
            FUNC_INSERT:
            begin
                if (!ins_legal)
                    status_next = ST_RANGE;
                else if (is_full)
                    status_next = ST_FULL;
                else
                    do_ins = 1'b1;
            end
            FUNC_REMOVE:
            begin
                if (is_empty)
                    status_next = ST_UNDERFLOW;
                else if (idx_ext >= fill_reg)
                    status_next = ST_RANGE;
                else
                begin
                    do_read = 1'b1;
                    do_rem  = 1'b1;
                end
            end
            FUNC_LOOKUP:
            begin
                if (idx_ext >= fill_reg)
                    status_next = ST_RANGE;
                else
                    do_read = 1'b1;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Growth on a write into a full list, shrink when a removal leaves it sparse.
    // A pop is a removal at the tail as far as the level is concerned.
    always_comb
    begin
        do_grow    = (do_push || do_ins) && at_cap && (level_reg < LEVEL_MAX);
        do_shrink  = (do_read && (do_rem || (func_t'(req.func) == FUNC_POP)))
                     && (level_reg >= LEVEL_SHRINK_MIN)
                     && (CMP_W'(fill_dec) < CMP_W'(shrink_bound));
        fill_next  = fill_reg;
        level_next = level_reg;
        if (do_push || do_ins)
            fill_next = fill_reg + FILL_W'(1);
        else if (do_shrink || (do_read && (do_rem || (func_t'(req.func) == FUNC_POP))))
            fill_next = fill_dec;
        if (do_grow)
            level_next = level_reg + LEVEL_W'(1);
        else if (do_shrink)
            level_next = level_reg - LEVEL_W'(1);
        cap_next  = fib_of(level_next);
        data_next = do_read ? rd_data : '0;
    end

    // Command to the cell chain, qualified by the accepted request.
    always_comb
    begin
        bcast.push_en = accept && do_push;
        bcast.ins_en  = accept && do_ins;
        bcast.rem_en  = accept && do_rem;
        bcast.index   = req.index;
        bcast.fill    = fill_reg;
        bcast.value   = req.value;
    end

    // List size and level state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            level_reg <= LEVEL_RESET;
            cap_reg   <= CAP_RESET;
        end
        else if (accept)
        begin
            fill_reg  <= fill_next;
            level_reg <= level_next;
            cap_reg   <= cap_next;
        end
    end

    // Response valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.data_out     = data_reg;
    assign rsp.fill         = fill_reg;
    assign rsp.capacity_now = cap_reg;

endmodule

`default_nettype wire

/* rtl/fibonacci_growth_list_buffer.sv */
// Fibonacci-growth list buffer. Each request (push, pop, insert, remove or lookup) is
// taken and its response appears in the response register on the next cycle,
// so the block sustains one request per clock while the response side keeps up. The list
// lives in a chain of cells, one word per cell; an insert or remove shifts the whole list
// as the request is taken, every cell choosing on its own to hold, load, or copy a neighbor.
// The word read by pop, remove or lookup is selected from the cells in the same cycle.
// The capacity follows the Fibonacci level and never limits the physical store of DEPTH
// words. Depends on fglb_pkg, fglb_if, fglb_cell and fglb_ctrl.
`default_nettype none

module fibonacci_growth_list_buffer
    import fglb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fglb_req_if.sink   req,
    fglb_rsp_if.source rsp
);

    bcast_t                       bcast;
    logic [IDX_W-1:0]             rd_idx;
    logic signed [DATA_WIDTH-1:0] rd_data;
    logic signed [DATA_WIDTH-1:0] words    [DEPTH];
    logic signed [DATA_WIDTH-1:0] rd_words [DEPTH];

    fglb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .rd_data (rd_data),
        .bcast   (bcast),
        .rd_idx  (rd_idx)
    );

    // Chain of cells, each linked to its left and right neighbor.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_WIDTH-1:0] left_w;
        logic signed [DATA_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = words[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = words[i+1];
        end

        fglb_cell u_cell (
            .clk        (clk),
            .pos        (IDX_W'(i)),
            .bcast      (bcast),
            .left_word  (left_w),
            .right_word (right_w),
            .rd_idx     (rd_idx),
            .word       (words[i]),
            .rd_word    (rd_words[i])
        );
    end

    // Only the addressed cell drives a nonzero word, so an OR merges the read.
    always_comb
    begin
        rd_data = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rd_data = rd_data | rd_words[k];
        end
    end

endmodule

`default_nettype wire

/* test/fibonacci_growth_list_buffer_tb.sv */
// Self-checking testbench for the Fibonacci-growth list buffer: random and directed list
// requests, an in-bench predictor of the list, level and capacity, and an in-order check.
// Depends on fglb_pkg, fglb_if and the fibonacci_growth_list_buffer RTL.
`default_nettype none

module fibonacci_growth_list_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fglb_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int REPORT_MAX  = 10;
    localparam int CHUNKS      = 17;
    localparam int CHUNK_ITEMS = 100;
    localparam int QUIET_CHUNK = 15;
    localparam int PAUSE_CHUNK = 7;

    localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = ~WORD_MIN;
    localparam logic signed [DATA_WIDTH-1:0] WORD_ODD = {(DATA_WIDTH/2){2'b01}};
    localparam logic signed [DATA_WIDTH-1:0] WORD_EVEN = {(DATA_WIDTH/2){2'b10}};

    // One list request and the response it should produce.
    typedef struct packed {
        logic [FUNC_W-1:0]            func;
        logic signed [DATA_WIDTH-1:0] value;
        logic [IDX_W-1:0]             index;
    } list_req_t;

    typedef struct packed {
        status_t                      status;
        logic signed [DATA_WIDTH-1:0] word;
        logic [FILL_W-1:0]            fill;
        logic [CAP_W-1:0]             capacity;
    } list_rsp_t;

    // Full state of a list: stored words, fill, Fibonacci level and capacity.
    typedef struct packed {
        logic [DEPTH-1:0][DATA_WIDTH-1:0] words;
        logic [FILL_W-1:0]                fill;
        logic [LEVEL_W-1:0]               level;
        logic [CAP_W-1:0]                 capacity;
    } list_state_t;

    // Traffic shapes of the random part.
    typedef enum int {
        SHAPE_GROW,
        SHAPE_DRAIN,
        SHAPE_MIX
    } shape_t;

    logic clk;
    logic rst_n;

    fglb_req_if req_ch ();
    fglb_rsp_if rsp_ch ();

    fibonacci_growth_list_buffer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_req_t   pending[$];
    list_rsp_t   expected_q[$];
    list_state_t model_state;
    list_state_t plan_state;
    list_req_t   on_wire;

    int send_gap;
    int recv_gap;
    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int requests_taken;
    int cycle_count;
    int status_hits[4];
    int peak_fill;
    int peak_capacity;

    // Fibonacci number of a level, built up by iteration.
    function automatic logic [CAP_W-1:0] fib_capacity(input logic [LEVEL_W-1:0] level);
        int a;
        int b;
        int t;
        a = 0;
        b = 1;
        for (int k = 0; k < level; k++)
        begin
            t = a + b;
            a = b;
            b = t;
        end
        return CAP_W'(a);
    endfunction

    function automatic list_state_t list_cleared();
        list_state_t st;
        st.words    = '0;
        st.fill     = '0;
        st.level    = LEVEL_RESET;
        st.capacity = CAP_RESET;
        return st;
    endfunction

    // A full list steps up one level before taking another word.
    function automatic void level_up(inout list_state_t st);
        if (st.fill == st.capacity && st.level < LEVEL_MAX)
        begin
            st.level    = st.level + 1'b1;
            st.capacity = fib_capacity(st.level);
        end
    endfunction

    // A sparse list steps down one level once fewer than fib(level-2) words remain.
    function automatic void level_down(inout list_state_t st, input int unsigned remaining);
        if (st.level >= LEVEL_SHRINK_MIN && remaining < fib_capacity(LEVEL_W'(st.level - 2)))
        begin
            st.level    = st.level - 1'b1;
            st.capacity = fib_capacity(st.level);
        end
    endfunction

    // Applies one request to a list and returns the response it yields.
    function automatic list_rsp_t list_apply(inout list_state_t st, input list_req_t rq);
        list_rsp_t   rs;
        int unsigned fill_now;
        int unsigned pos;
        rs.status = ST_OK;
        rs.word   = '0;
        fill_now  = 32'(st.fill);
        pos       = 32'(rq.index);
        case (rq.func)
            FUNC_PUSH:
            begin
                if (fill_now >= DEPTH)
                    rs.status = ST_FULL;
                else
                begin
                    level_up(st);
                    st.words[fill_now] = rq.value;
                    st.fill = st.fill + 1'b1;
                end
            end
            FUNC_POP:
            begin
                if (fill_now == 0)
                    rs.status = ST_UNDERFLOW;
                else
                begin
                    rs.word = st.words[fill_now - 1];
                    st.fill = st.fill - 1'b1;
                    level_down(st, 32'(st.fill));
                end
            end
            FUNC_INSERT:
            begin
                // Insert only lands inside the list, or at the head of an empty one.
                if (!(pos < fill_now || (fill_now == 0 && pos == 0)))
                    rs.status = ST_RANGE;
                else if (fill_now >= DEPTH)
                    rs.status = ST_FULL;
                else
                begin
                    level_up(st);
                    for (int i = fill_now; i > pos; i--)
                        st.words[i] = st.words[i - 1];
                    st.words[pos] = rq.value;
                    st.fill = st.fill + 1'b1;
                end
            end
            FUNC_REMOVE:
            begin
                if (fill_now == 0)
                    rs.status = ST_UNDERFLOW;
                else if (pos >= fill_now)
                    rs.status = ST_RANGE;
                else
                begin
                    rs.word = st.words[pos];
                    level_down(st, fill_now - 1);
                    st.fill = st.fill - 1'b1;
                    for (int i = pos; i < fill_now - 1; i++)
                        st.words[i] = st.words[i + 1];
                end
            end
            FUNC_LOOKUP:
            begin
                if (pos >= fill_now)
                    rs.status = ST_RANGE;
                else
                    rs.word = st.words[pos];
            end
            default:
            begin
            end
        endcase
        rs.fill     = st.fill;
        rs.capacity = st.capacity;
        return rs;
    endfunction

    function automatic void check_field(input string field, input logic [DATA_WIDTH-1:0] want,
                                        input logic [DATA_WIDTH-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field,
                         want, got);
        end
    endfunction

    // Operation mix of each traffic shape, with a thin sprinkle of unused codes.
    function automatic logic [FUNC_W-1:0] pick_op(input shape_t shape);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r >= 98)
            return FUNC_W'($urandom_range(FUNC_LOOKUP + 1, (1 << FUNC_W) - 1));
        case (shape)
            SHAPE_GROW:
                return r < 45 ? FUNC_PUSH : r < 75 ? FUNC_INSERT : r < 88 ? FUNC_LOOKUP :
                       r < 93 ? FUNC_POP : FUNC_REMOVE;
            SHAPE_DRAIN:
                return r < 35 ? FUNC_POP : r < 70 ? FUNC_REMOVE : r < 85 ? FUNC_LOOKUP :
                       r < 92 ? FUNC_PUSH : FUNC_INSERT;
            default:
                return r < 20 ? FUNC_PUSH : r < 40 ? FUNC_POP : r < 60 ? FUNC_INSERT :
                       r < 80 ? FUNC_REMOVE : FUNC_LOOKUP;
        endcase
    endfunction

    // Mostly a position inside the list, sometimes one past its end or anywhere.
    function automatic logic [IDX_W-1:0] pick_index(input int unsigned fill_now);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return IDX_W'($urandom_range(0, DEPTH - 1));
        if (r == 1 || fill_now == 0)
            return IDX_W'(fill_now);
        return IDX_W'($urandom_range(0, fill_now - 1));
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            default: return DATA_WIDTH'($urandom());
        endcase
    endfunction

    task automatic queue_request(input logic [FUNC_W-1:0] op,
                                 input logic signed [DATA_WIDTH-1:0] word,
                                 input logic [IDX_W-1:0] pos);
        list_req_t rq;
        rq.func  = op;
        rq.value = word;
        rq.index = pos;
        void'(list_apply(plan_state, rq));
        pending.push_back(rq);
    endtask

    task automatic wait_for_drain();
        while (pending.size() != 0 || req_ch.valid || expected_q.size() != 0)
            @(negedge clk);
    endtask

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run timeout.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d responses outstanding.", cycle_count,
                     expected_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Request driver: presents queued requests and predicts each one as it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.func  <= '0;
            req_ch.value <= '0;
            req_ch.index <= '0;
            send_gap = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_q.push_back(list_apply(model_state, on_wire));
                requests_taken++;
                if (32'(model_state.fill) > peak_fill)
                    peak_fill = 32'(model_state.fill);
                if (32'(model_state.capacity) > peak_capacity)
                    peak_capacity = 32'(model_state.capacity);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending.size() != 0 && send_idle_pct > 0 &&
                         $urandom_range(0, 99) < send_idle_pct)
                begin
                    send_gap = $urandom_range(0, 5);
                    req_ch.valid <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    on_wire = pending.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.func  <= on_wire.func;
                    req_ch.value <= on_wire.value;
                    req_ch.index <= on_wire.index;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor: stalls at random and checks each response against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        list_rsp_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t ns: response with no request outstanding", $time);
                end
                else
                begin
                    want = expected_q.pop_front();
                    status_hits[want.status]++;
                    check_field("status", DATA_WIDTH'(want.status),
                                DATA_WIDTH'(rsp_ch.status));
                    check_field("data_out", want.word, rsp_ch.data_out);
                    check_field("fill", DATA_WIDTH'(want.fill), DATA_WIDTH'(rsp_ch.fill));
                    check_field("capacity_now", DATA_WIDTH'(want.capacity),
                                DATA_WIDTH'(rsp_ch.capacity_now));
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                recv_gap = $urandom_range(0, 5);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Stimulus: reset, a directed pass over the corner cases, then shaped random traffic.
    initial
    begin
        shape_t shape;
        int     full_visits;
        int     empty_visits;
        int     stay_count;

        rst_n <= 1'b0;
        model_state   = list_cleared();
        plan_state    = list_cleared();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty list: underflow, out-of-range lookup and insert past the head.
        queue_request(FUNC_POP, '0, '0);
        queue_request(FUNC_REMOVE, '0, '0);
        queue_request(FUNC_LOOKUP, '0, '0);
        queue_request(FUNC_INSERT, WORD_ODD, IDX_W'(1));
        // Growth from the first words, a middle insert and a refused append by insert.
        queue_request(FUNC_INSERT, WORD_MAX, '0);
        queue_request(FUNC_PUSH, WORD_MIN, '1);
        queue_request(FUNC_INSERT, '0, IDX_W'(1));
        queue_request(FUNC_INSERT, WORD_EVEN, IDX_W'(3));
        queue_request(FUNC_PUSH, '1, '0);
        queue_request(FUNC_PUSH, WORD_ODD, '0);
        queue_request(FUNC_PUSH, WORD_EVEN, '0);
        // Lookups at both ends, one past the end and at the top index.
        queue_request(FUNC_LOOKUP, '0, '0);
        queue_request(FUNC_LOOKUP, '0, IDX_W'(5));
        queue_request(FUNC_LOOKUP, '0, IDX_W'(6));
        queue_request(FUNC_LOOKUP, '0, '1);
        queue_request(FUNC_REMOVE, '0, '1);
        queue_request(FUNC_REMOVE, '0, IDX_W'(1));
        queue_request(FUNC_REMOVE, '0, '0);
        // Unused operation codes leave the list alone.
        for (int op = FUNC_LOOKUP + 1; op < (1 << FUNC_W); op++)
            queue_request(FUNC_W'(op), '1, '1);
        // Drain to empty so the capacity falls back.
        repeat (4) queue_request(FUNC_POP, '0, '0);
        wait_for_drain();

        shape        = SHAPE_GROW;
        full_visits  = 0;
        empty_visits = 0;
        stay_count   = 0;
        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            // Each stretch gets its own idling profile; the tail runs at full rate.
            if (chunk >= QUIET_CHUNK)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                    1:
                    begin
                        send_idle_pct = 25;
                        recv_idle_pct = 0;
                    end
                    2:
                    begin
                        send_idle_pct = 0;
                        recv_idle_pct = 25;
                    end
                    default:
                    begin
                        send_idle_pct = 15;
                        recv_idle_pct = 15;
                    end
                endcase
            end

            for (int n = 0; n < CHUNK_ITEMS; n++)
            begin
                queue_request(pick_op(shape), pick_word(), pick_index(32'(plan_state.fill)));
                stay_count++;
                // Fill to the physical limit, linger there, drain to empty, repeat, at times via a mixed stretch.
                case (shape)
                    SHAPE_GROW:
                    begin
                        if (plan_state.fill == DEPTH)
                            full_visits++;
                        if (full_visits > 5)
                        begin
                            shape       = SHAPE_DRAIN;
                            full_visits = 0;
                        end
                    end
                    SHAPE_DRAIN:
                    begin
                        if (plan_state.fill == 0)
                            empty_visits++;
                        if (empty_visits > 3)
                        begin
                            shape        = ($urandom_range(0, 2) == 0) ? SHAPE_MIX : SHAPE_GROW;
                            empty_visits = 0;
                            stay_count   = 0;
                        end
                    end
                    default:
                    begin
                        if (stay_count > 40)
                            shape = SHAPE_GROW;
                    end
                endcase
            end

            // Let this stretch play out under its own profile before the next one.
            while (pending.size() != 0)
                @(negedge clk);
            if (chunk == PAUSE_CHUNK)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (8) @(negedge clk);

        $display("Covered %0d requests: %0d ok, %0d underflow, %0d out of range, %0d store full.",
                 requests_taken, status_hits[ST_OK], status_hits[ST_UNDERFLOW],
                 status_hits[ST_RANGE], status_hits[ST_FULL]);
        $display("Fill peaked at %0d of %0d words, capacity at %0d; %0d mismatches.",
                 peak_fill, DEPTH, peak_capacity, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
